// ----- src/websocket_frame_receiver_core_defines.svh -----
// Assertion macros shared by the frame receiver RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef WEBSOCKET_FRAME_RECEIVER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication check, disabled during reset.
`define WFR_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// Next-cycle implication check, disabled during reset.
`define WFR_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

// ----- src/wfr_pkg.sv -----
// Shared types and constants for the frame receiver.
// Used by the front parser, the command queue, the back sequencer and the top level.
package wfr_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_TEXT     = 3'd1;
  localparam logic [2:0] ST_PONG     = 3'd2;
  localparam logic [2:0] ST_PING     = 3'd3;
  localparam logic [2:0] ST_CLOSE    = 3'd4;
  localparam logic [2:0] ST_TOOBIG   = 3'd5;
  localparam logic [2:0] ST_FRAGMENT = 3'd6;
  localparam logic [2:0] ST_UNHANDLED = 3'd7;

  localparam logic [1:0] OK_PAYLOAD = 2'd0;
  localparam logic [1:0] OK_REPLY   = 2'd1;
  localparam logic [1:0] OK_STATUS  = 2'd2;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [7:0] RB_CLOSE_HDR = 8'h88;
  localparam logic [7:0] RB_PONG_HDR  = 8'h8A;
  localparam logic [7:0] RB_ZERO      = 8'h00;
  localparam logic [7:0] RB_REJ0      = 8'h08;
  localparam logic [7:0] RB_REJ1      = 8'h02;
  localparam logic [7:0] RB_REJ2      = 8'h03;
  localparam logic [7:0] RB_REJ3      = 8'hF1;

  typedef struct packed {
    logic       has_payload;
    logic [7:0] payload;
    logic [2:0] status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- src/wfr_front.sv -----
// Front parser: walks the frame header, mask and payload one link byte per word.
// Emits one command per word that causes results. Depends on wfr_pkg.
module wfr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [15:0]       cfg_wdata,
  input  logic              accept,
  input  logic              in_kind,
  input  logic [7:0]        in_byte,
  output logic              push,
  output wfr_pkg::cmd_t     cmd
);
  import wfr_pkg::*;

  localparam logic [2:0] PH_HDR   = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_LENHI = 3'd2;
  localparam logic [2:0] PH_LENLO = 3'd3;
  localparam logic [2:0] PH_MASK  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;

  logic [15:0] max_len;
  logic [2:0]  phase, phase_next;
  logic [3:0]  opcode, opcode_next;
  logic        fin, fin_next;
  logic        masked, masked_next;
  logic [15:0] len, len_next;
  logic [15:0] pos, pos_next;
  logic        link_open, link_open_next;
  logic [7:0]  key [4];
  logic        check_len, mask_done, finish, clear;
  logic [15:0] pos_inc;

  assign pos_inc = pos + 16'd1;

  always_comb begin
    phase_next     = phase;
    opcode_next    = opcode;
    fin_next       = fin;
    masked_next    = masked;
    len_next       = len;
    pos_next       = pos;
    link_open_next = link_open;
    cmd            = '0;
    check_len      = 1'b0;
    mask_done      = 1'b0;
    finish         = 1'b0;
    clear          = 1'b0;
    if (accept) begin
      if (in_kind) begin
        clear          = 1'b1;
        link_open_next = 1'b1;
      end else if (link_open) begin
        case (phase)
          PH_HDR: begin
            opcode_next = in_byte[3:0];
            fin_next    = in_byte[7];
            phase_next  = PH_LEN;
          end
          PH_LEN: begin
            masked_next = in_byte[7];
            len_next    = {9'd0, in_byte[6:0]};
            if (in_byte[6:0] == 7'd126) begin
              phase_next = PH_LENHI;
            end else begin
              check_len = 1'b1;
            end
          end
          PH_LENHI: begin
            len_next   = {in_byte, 8'd0};
            phase_next = PH_LENLO;
          end
          PH_LENLO: begin
            len_next  = {len[15:8], in_byte};
            check_len = 1'b1;
          end
          PH_MASK: begin
            pos_next = pos_inc;
            if (pos[1:0] == 2'd3) begin
              mask_done = 1'b1;
            end
          end
          PH_DATA: begin
            cmd.has_payload = fin && (opcode == OP_TEXT);
            cmd.payload     = masked ? (in_byte ^ key[pos[1:0]]) : in_byte;
            pos_next        = pos_inc;
            if (pos_inc >= len) begin
              finish = 1'b1;
            end
          end
          default: begin
            clear = 1'b1;
          end
        endcase

        if (check_len) begin
          if (len_next > max_len) begin
            cmd.status     = ST_TOOBIG;
            link_open_next = 1'b0;
            clear          = 1'b1;
          end else if (masked_next) begin
            phase_next = PH_MASK;
            pos_next   = 16'd0;
          end else begin
            mask_done = 1'b1;
          end
        end

        if (mask_done && !clear) begin
          pos_next = 16'd0;
          if (len_next == 16'd0) begin
            finish = 1'b1;
          end else begin
            phase_next = PH_DATA;
          end
        end

        if (finish) begin
          clear = 1'b1;
          if (!fin) begin
            cmd.status     = ST_FRAGMENT;
            link_open_next = 1'b0;
          end else begin
            case (opcode)
              OP_TEXT:  cmd.status = ST_TEXT;
              OP_PING:  cmd.status = ST_PING;
              OP_PONG:  cmd.status = ST_PONG;
              OP_CLOSE: begin
                cmd.status     = ST_CLOSE;
                link_open_next = 1'b0;
              end
              default: begin
                cmd.status     = ST_UNHANDLED;
                link_open_next = 1'b0;
              end
            endcase
          end
        end
      end

      if (clear) begin
        phase_next  = PH_HDR;
        opcode_next = 4'd0;
        fin_next    = 1'b0;
        masked_next = 1'b0;
        len_next    = 16'd0;
        pos_next    = 16'd0;
      end
    end
  end

  assign push = accept && (cmd.has_payload || (cmd.status != ST_NONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len   <= 16'd128;
      phase     <= PH_HDR;
      opcode    <= 4'd0;
      fin       <= 1'b0;
      masked    <= 1'b0;
      len       <= 16'd0;
      pos       <= 16'd0;
      link_open <= 1'b1;
    end else begin
      if (cfg_wen) begin
        max_len <= cfg_wdata;
      end
      phase     <= phase_next;
      opcode    <= opcode_next;
      fin       <= fin_next;
      masked    <= masked_next;
      len       <= len_next;
      pos       <= pos_next;
      link_open <= link_open_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_kind && link_open && (phase == PH_MASK)) begin
      key[pos[1:0]] <= in_byte;
    end
  end

endmodule

// ----- src/wfr_queue.sv -----
// Short command queue between the front parser and the back sequencer.
// Show-ahead register queue; depends on wfr_pkg for depth and command type.
module wfr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wfr_pkg::cmd_t       push_cmd,
  input  logic                pop,
  output wfr_pkg::cmd_t       head,
  output wfr_pkg::q_status_t  status
);
  import wfr_pkg::*;

  cmd_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign status.full  = (count == QDEPTH[QAW:0]);
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- src/wfr_back.sv -----
// Back sequencer: expands each queued command into payload, reply and status words.
// Drives the registered output channel. Depends on wfr_pkg.
module wfr_back (
  input  logic                clk,
  input  logic                rst,
  input  wfr_pkg::cmd_t       head,
  input  wfr_pkg::q_status_t  q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic [2:0]          out_status
);
  import wfr_pkg::*;

  logic [2:0] step;
  logic [2:0] reply_cnt;
  logic [2:0] total;
  logic [2:0] j;
  logic [1:0] e_kind;
  logic [7:0] e_byte;
  logic [2:0] e_status;
  logic       e_last;
  logic       load;

  always_comb begin
    case (head.status)
      ST_PING, ST_CLOSE:     reply_cnt = 3'd2;
      ST_TOOBIG, ST_FRAGMENT: reply_cnt = 3'd4;
      default:               reply_cnt = 3'd0;
    endcase
    total = {2'd0, head.has_payload} + reply_cnt + {2'd0, head.status != ST_NONE};
    j     = step - {2'd0, head.has_payload};
    e_last = (step == total - 3'd1);

    e_kind   = OK_STATUS;
    e_byte   = 8'd0;
    e_status = head.status;
    if (head.has_payload && (step == 3'd0)) begin
      e_kind   = OK_PAYLOAD;
      e_byte   = head.payload;
      e_status = ST_NONE;
    end else if (j < reply_cnt) begin
      e_kind   = OK_REPLY;
      e_status = ST_NONE;
      if (reply_cnt == 3'd2) begin
        if (j == 3'd0) begin
          e_byte = (head.status == ST_PING) ? RB_PONG_HDR : RB_CLOSE_HDR;
        end else begin
          e_byte = RB_ZERO;
        end
      end else begin
        case (j)
          3'd0:    e_byte = RB_REJ0;
          3'd1:    e_byte = RB_REJ1;
          3'd2:    e_byte = RB_REJ2;
          default: e_byte = RB_REJ3;
        endcase
      end
    end
  end

  assign load = !q_status.empty && (!out_valid || out_ready);
  assign pop  = load && e_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= 3'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      step      <= e_last ? 3'd0 : step + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind   <= e_kind;
      out_byte   <= e_byte;
      out_last   <= e_last;
      out_status <= e_status;
    end
  end

endmodule

// ----- src/websocket_frame_receiver_core.sv -----
// Top level of the frame receiver: front parser, command queue and back sequencer.
// Depends on wfr_pkg, wfr_front, wfr_queue, wfr_back and the assertion header.
//
// The slave channel and parser take one word per cycle while s_tready is high:
// s_tdata carries a link byte and s_tuser marks a reopen word, which clears
// frame state and reopens the link. The master channel returns result words:
// unmasked text payload, reply bytes for the peer and one status word at the
// end of each frame; m_tlast marks the last word caused by one input word.
// cfg_wen and cfg_wdata set the largest accepted payload length; the user must
// write them only while the block is idle, which the block does not enforce. A
// word that ends a frame can cause up to five results, which the back sequencer
// sends one per cycle while m_tready is high. A four-entry command queue
// between the parser and the output register decouples the two sides; s_tready
// drops only when that queue is full, so a stalled m_tready eventually backs up
// the input. Reset clears the parser to await a frame header with the link
// open, empties the queue, drops m_tvalid and sets the length limit to 128.
`include "websocket_frame_receiver_core_defines.svh"
module websocket_frame_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] frame_status, rest zero
  output logic [1:0]  m_tuser,   // [1:0] out_kind
  output logic        m_tlast
);
  import wfr_pkg::*;

  logic      accept;
  logic      push;
  cmd_t      push_cmd;
  cmd_t      head;
  q_status_t q_status;
  logic      pop;
  logic [7:0] out_byte;
  logic [2:0] out_status;

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {5'd0, out_status, out_byte};

  wfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_kind   (s_tuser),
    .in_byte   (s_tdata),
    .push      (push),
    .cmd       (push_cmd)
  );

  wfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  wfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_byte   (out_byte),
    .out_last   (m_tlast),
    .out_status (out_status)
  );

  `WFR_ASSERT_NOW(a_no_pop_when_stalled, clk, rst, m_tvalid && !m_tready, !pop)
  `WFR_ASSERT_NOW(a_push_has_results, clk, rst, push,
    push_cmd.has_payload || (push_cmd.status != ST_NONE))
  `WFR_ASSERT_NOW(a_status_word_coded, clk, rst, m_tvalid && (m_tuser == OK_STATUS),
    (out_status != ST_NONE) && m_tlast)
  `WFR_ASSERT_NEXT(a_reopen_no_results, clk, rst, accept && s_tuser && q_status.empty && !m_tvalid,
    !m_tvalid)

endmodule

// ----- tb/frame_receiver_checker.sv -----
// Checker for the frame receiver: predicts result words from the accepted input words.
// It compares each accepted result word with the oldest prediction and counts mismatches.
// Depends on wfr_pkg for the result kinds, status codes, opcodes and reply bytes.
module frame_receiver_checker
  import wfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  output int          mismatches,
  output int          owed_count
);

  localparam logic [6:0]  LEN_EXT16   = 7'd126;
  localparam logic [15:0] KEY_BYTES   = 16'd4;
  localparam logic [15:0] RESET_LIMIT = 16'd128;

  typedef enum logic [2:0] {
    AWAIT_HEAD,
    AWAIT_LEN,
    AWAIT_LEN_HI,
    AWAIT_LEN_LO,
    AWAIT_KEY,
    IN_PAYLOAD
  } parse_phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic [2:0] status;
  } out_word_t;

  out_word_t    owed_words[$];
  parse_phase_e phase;
  logic [3:0]   hdr_opcode;
  logic         hdr_fin;
  logic         hdr_masked;
  logic [15:0]  frame_len;
  logic [15:0]  body_pos;
  logic [7:0]   mask_bytes[4];
  logic [15:0]  len_limit;
  logic         accepting;

  function automatic void clear_frame();
    phase      = AWAIT_HEAD;
    hdr_opcode = '0;
    hdr_fin    = 1'b0;
    hdr_masked = 1'b0;
    frame_len  = '0;
    body_pos   = '0;
    mask_bytes = '{default: 8'h00};
  endfunction

  function automatic void owe(logic [1:0] kind, logic [7:0] data, logic [2:0] status);
    owed_words.push_back('{kind: kind, data: data, last: 1'b0, status: status});
  endfunction

  function automatic void reject_frame(logic [2:0] status);
    owe(OK_REPLY, RB_REJ0, ST_NONE);
    owe(OK_REPLY, RB_REJ1, ST_NONE);
    owe(OK_REPLY, RB_REJ2, ST_NONE);
    owe(OK_REPLY, RB_REJ3, ST_NONE);
    owe(OK_STATUS, RB_ZERO, status);
    clear_frame();
    accepting = 1'b0;
  endfunction

  function automatic void end_frame();
    if (!hdr_fin) begin
      reject_frame(ST_FRAGMENT);
    end else begin
      case (hdr_opcode)
        OP_TEXT: begin
          owe(OK_STATUS, RB_ZERO, ST_TEXT);
          clear_frame();
        end
        OP_CLOSE: begin
          owe(OK_REPLY, RB_CLOSE_HDR, ST_NONE);
          owe(OK_REPLY, RB_ZERO, ST_NONE);
          owe(OK_STATUS, RB_ZERO, ST_CLOSE);
          clear_frame();
          accepting = 1'b0;
        end
        OP_PING: begin
          owe(OK_REPLY, RB_PONG_HDR, ST_NONE);
          owe(OK_REPLY, RB_ZERO, ST_NONE);
          owe(OK_STATUS, RB_ZERO, ST_PING);
          clear_frame();
        end
        OP_PONG: begin
          owe(OK_STATUS, RB_ZERO, ST_PONG);
          clear_frame();
        end
        default: begin
          owe(OK_STATUS, RB_ZERO, ST_UNHANDLED);
          clear_frame();
          accepting = 1'b0;
        end
      endcase
    end
  endfunction

  function automatic void key_done();
    body_pos = '0;
    if (frame_len == 16'd0) begin
      end_frame();
    end else begin
      phase = IN_PAYLOAD;
    end
  endfunction

  function automatic void length_known();
    if (frame_len > len_limit) begin
      reject_frame(ST_TOOBIG);
    end else if (hdr_masked) begin
      phase    = AWAIT_KEY;
      body_pos = '0;
    end else begin
      key_done();
    end
  endfunction

  function automatic void parse_link_word(logic reopen, logic [7:0] b);
    int unsigned base;
    logic [7:0]  plain;
    base = owed_words.size();
    if (reopen) begin
      clear_frame();
      accepting = 1'b1;
      return;
    end
    if (!accepting) return;
    case (phase)
      AWAIT_HEAD: begin
        hdr_opcode = b[3:0];
        hdr_fin    = b[7];
        phase      = AWAIT_LEN;
      end
      AWAIT_LEN: begin
        hdr_masked = b[7];
        frame_len  = {9'd0, b[6:0]};
        if (b[6:0] == LEN_EXT16) begin
          phase = AWAIT_LEN_HI;
        end else begin
          length_known();
        end
      end
      AWAIT_LEN_HI: begin
        frame_len = {b, 8'd0};
        phase     = AWAIT_LEN_LO;
      end
      AWAIT_LEN_LO: begin
        frame_len = {frame_len[15:8], b};
        length_known();
      end
      AWAIT_KEY: begin
        mask_bytes[body_pos[1:0]] = b;
        body_pos = body_pos + 16'd1;
        if (body_pos >= KEY_BYTES) key_done();
      end
      IN_PAYLOAD: begin
        plain = hdr_masked ? (b ^ mask_bytes[body_pos[1:0]]) : b;
        if (hdr_fin && hdr_opcode == OP_TEXT) owe(OK_PAYLOAD, plain, ST_NONE);
        body_pos = body_pos + 16'd1;
        if (body_pos >= frame_len) end_frame();
      end
      default: clear_frame();
    endcase
    if (owed_words.size() > base) owed_words[owed_words.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      owed_words.delete();
      clear_frame();
      accepting  = 1'b1;
      len_limit  = RESET_LIMIT;
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_words.size() == 0) begin
          $error("unexpected result word: kind %0d, byte %0h, status %0d",
                 m_tuser, m_tdata[7:0], m_tdata[10:8]);
          mismatches++;
        end else begin
          want = owed_words.pop_front();
          check_field("out_kind", want.kind, m_tuser);
          check_field("out_byte", want.data, m_tdata[7:0]);
          check_field("out_last", want.last, m_tlast);
          check_field("frame_status", want.status, m_tdata[10:8]);
        end
      end
      if (cfg_wen) len_limit = cfg_wdata;
      if (s_tvalid && s_tready) parse_link_word(s_tuser, s_tdata);
    end
    owed_count <= owed_words.size();
  end

endmodule

// ----- tb/tb.sv -----
// Top of the frame receiver testbench: clock, reset, stimulus, sink stalls and verdict.
// It drives directed and random WebSocket frames through several idle and limit settings.
// Depends on wfr_pkg, websocket_frame_receiver_core and frame_receiver_checker.
module tb;
  import wfr_pkg::*;

  localparam int          CLK_HALF      = 10;
  localparam int          RESET_CYCLES  = 6;
  localparam int          LIMIT_CYCLES  = 400000;
  localparam int          SETTLE_CYCLES = 10;
  localparam int          PHASE_ITEMS   = 60;
  localparam int          PHASES        = 4;
  localparam logic [3:0]  OP_RESERVED   = 4'hF;
  localparam logic [15:0] LEN_LITERAL   = 16'd127;
  localparam logic [15:0] LEN_EXT16     = 16'd126;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_wen   = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int          mismatches;
  int          owed_count;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned cycle_count   = 0;
  logic        link_up       = 1'b1;
  logic [15:0] cur_max       = 16'd128;

  always #CLK_HALF clk = ~clk;

  websocket_frame_receiver_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  frame_receiver_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .mismatches(mismatches),
    .owed_count(owed_count)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_word(input logic kind, input logic [7:0] b);
    logic taken;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end
    if (kind || link_up) items_sent++;
    if (kind) link_up = 1'b1;
  endtask

  task automatic reopen();
    send_word(1'b1, 8'($urandom));
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (owed_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    cur_max = value;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic send_frame(input logic fin, input logic [3:0] opcode, input logic masked,
                            input logic [15:0] len, input logic ext);
    send_word(1'b0, {fin, 3'($urandom_range(7)), opcode});
    if (ext) begin
      send_word(1'b0, {masked, LEN_EXT16[6:0]});
      send_word(1'b0, len[15:8]);
      send_word(1'b0, len[7:0]);
    end else begin
      send_word(1'b0, {masked, len[6:0]});
    end
    if (len > cur_max) begin
      link_up = 1'b0;
      return;
    end
    if (masked) repeat (4) send_word(1'b0, 8'($urandom));
    repeat (len) send_word(1'b0, 8'($urandom));
    if (!fin || !(opcode == OP_TEXT || opcode == OP_PING || opcode == OP_PONG))
      link_up = 1'b0;
  endtask

  task automatic random_frame();
    logic        fin;
    logic        masked;
    logic        ext;
    logic [3:0]  opcode;
    logic [15:0] len;
    int unsigned r;
    r = $urandom_range(99);
    opcode = (r < 50) ? OP_TEXT :
             (r < 62) ? OP_PING :
             (r < 72) ? OP_PONG :
             (r < 80) ? OP_CLOSE : 4'($urandom_range(15));
    fin    = ($urandom_range(9) != 0);
    masked = $urandom_range(1);
    r = $urandom_range(99);
    if (r < 4) len = LEN_LITERAL;
    else if (r < 14 && cur_max <= 16'd40) len = cur_max + 16'($urandom_range(1));
    else if (r < 20 && cur_max < 16'd200) len = 16'($urandom);
    else len = 16'($urandom_range(12));
    ext = (len > LEN_LITERAL || len == LEN_EXT16) ? 1'b1 : ($urandom_range(4) == 0);
    send_frame(fin, opcode, masked, len, ext);
    if (!link_up) begin
      repeat ($urandom_range(2)) send_word(1'b0, 8'($urandom));
      reopen();
    end
  endtask

  initial begin
    logic [15:0] limits[PHASES];
    int unsigned src_pcts[PHASES];
    int unsigned snk_pcts[PHASES];
    int unsigned target;
    int unsigned halfway;
    int unsigned r;
    logic        paused;

    limits   = '{16'hFFFF, 16'h0000, 16'd7, 16'($urandom_range(8, 40))};
    src_pcts = '{0, 77, 0, 20};
    snk_pcts = '{0, 0, 77, 20};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_frame(1'b1, OP_PING, 1'b0, 16'd0, 1'b0);
    send_frame(1'b1, OP_TEXT, 1'b1, 16'd2, 1'b0);
    send_frame(1'b1, OP_PONG, 1'b0, 16'd1, 1'b0);
    send_frame(1'b0, OP_TEXT, 1'b0, 16'd0, 1'b0);
    send_word(1'b0, {1'b1, 3'b000, OP_TEXT});
    reopen();
    send_frame(1'b1, OP_TEXT, 1'b0, 16'hFFFF, 1'b1);
    reopen();
    send_frame(1'b1, OP_CLOSE, 1'b1, 16'd0, 1'b0);
    reopen();
    send_frame(1'b1, OP_RESERVED, 1'b0, 16'd0, 1'b0);
    reopen();
    send_word(1'b0, {1'b1, 3'b000, OP_TEXT});
    send_word(1'b0, 8'h05);
    reopen();

    for (int p = 0; p < PHASES; p++) begin
      write_limit(limits[p]);
      src_idle_pct  = src_pcts[p];
      snk_stall_pct = snk_pcts[p];
      target  = items_sent + PHASE_ITEMS;
      halfway = items_sent + PHASE_ITEMS / 2;
      paused  = 1'b0;
      while (items_sent < target) begin
        r = $urandom_range(99);
        if (r < 82) begin
          random_frame();
        end else if (r < 92) begin
          repeat (1 + $urandom_range(2)) send_word(1'b0, 8'($urandom));
          reopen();
        end else begin
          send_word(1'($urandom_range(1)), 8'($urandom));
          reopen();
        end
        if (!paused && items_sent >= halfway) begin
          wait_for_results();
          paused = 1'b1;
        end
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
